>>> src/mtkf_pkg.sv
`timescale 1ns / 1ps

package mtkf_pkg;

  localparam int MAX_DIM_DEF = 256;
  localparam int RADIUS_DEF  = 15;

  localparam int TILE_W    = 8;
  localparam int DIM_REG_W = 9;
  localparam int FERT_W    = 17;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // bit-serial remainder: one dividend bit per cycle
  localparam int MOD_STEPS = TILE_W;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // register index as decoded from paddr[2]
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(256);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SEED,
    ST_PRE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic we;
    logic water;
    logic sand;
  } store_wr_t;

endpackage

>>> src/mtkf_if.sv
`timescale 1ns / 1ps

interface mtkf_in_if import mtkf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [TILE_W-1:0] tile_x;
  logic [TILE_W-1:0] tile_y;
  logic              water_flag;
  logic              sand_flag;

  modport source (output valid, func, tile_x, tile_y, water_flag, sand_flag, input ready);
  modport sink (input valid, func, tile_x, tile_y, water_flag, sand_flag, output ready);
endinterface

interface mtkf_out_if import mtkf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FERT_W-1:0] fertility;

  modport source (output valid, fertility, input ready);
  modport sink (input valid, fertility, output ready);
endinterface

>>> src/mtkf_rem.sv
`timescale 1ns / 1ps

module mtkf_rem import mtkf_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [TILE_W-1:0]            dividend,
  input  logic [$clog2(MAX_DIM+1)-1:0] divisor,
  output logic [$clog2(MAX_DIM)-1:0]   rem
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  logic [TILE_W-1:0] dvd_r;
  logic [CW-1:0]     rem_r;
  logic [DW:0]       trial;
  logic [CW-1:0]     rem_nxt;

  // shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    trial = {DW'(rem_r), dvd_r[TILE_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = CW'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = CW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (step) begin
      dvd_r <= {dvd_r[TILE_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule

>>> src/mtkf_store.sv
`timescale 1ns / 1ps

module mtkf_store import mtkf_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                           clk,
  input  store_wr_t                      wr,
  input  logic [2*$clog2(MAX_DIM)-1:0]   wr_addr,
  input  logic                           rd_en,
  input  logic [2*$clog2(MAX_DIM)-1:0]   water_addr,
  input  logic [2*$clog2(MAX_DIM)-1:0]   sand_addr,
  output logic                           water_bit,
  output logic                           sand_bit
);

  localparam int AW    = 2 * $clog2(MAX_DIM);
  localparam int DEPTH = 1 << AW;

  logic water_mem [DEPTH];
  logic sand_mem  [DEPTH];

  logic [AW-1:0] water_port;
  logic [AW-1:0] sand_port;

  // one port per memory: a write takes the port from the read
  assign water_port = wr.we ? wr_addr : water_addr;
  assign sand_port  = wr.we ? wr_addr : sand_addr;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      water_mem[water_port] <= wr.water;
    end else if (rd_en) begin
      water_bit <= water_mem[water_port];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      sand_mem[sand_port] <= wr.sand;
    end else if (rd_en) begin
      sand_bit <= sand_mem[sand_port];
    end
  end

endmodule

>>> src/mtkf_ctrl.sv
`timescale 1ns / 1ps

module mtkf_ctrl import mtkf_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int RADIUS  = RADIUS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [TILE_W-1:0]            in_tile_x,
  input  logic [TILE_W-1:0]            in_tile_y,
  input  logic                         in_water,
  input  logic                         in_sand,
  input  logic [$clog2(MAX_DIM+1)-1:0] w_eff,
  input  logic [$clog2(MAX_DIM+1)-1:0] h_eff,
  output store_wr_t                    wr,
  output logic [2*$clog2(MAX_DIM)-1:0] wr_addr,
  output logic                         rd_en,
  output logic [2*$clog2(MAX_DIM)-1:0] water_addr,
  output logic [2*$clog2(MAX_DIM)-1:0] sand_addr,
  input  logic                         water_bit,
  input  logic                         sand_bit,
  input  logic                         out_free,
  output logic                         push,
  output logic [FERT_W-1:0]            push_data
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int KMAX = 2 * RADIUS;
  localparam int KW   = $clog2(KMAX + 1);
  localparam int WW   = $clog2(RADIUS + 2);
  localparam int PW   = 2 * WW;
  localparam int SMAX = (RADIUS > MOD_STEPS) ? RADIUS : MOD_STEPS;
  localparam int SW   = $clog2(SMAX + 1);

  function automatic logic [CW-1:0] inc_wrap(input logic [CW-1:0] c, input logic [DW-1:0] n);
    logic [DW-1:0] c1;
    c1 = DW'(c) + DW'(1);
    return (c1 == n) ? '0 : CW'(c1);
  endfunction

  function automatic logic [CW-1:0] dec_wrap(input logic [CW-1:0] c, input logic [DW-1:0] n);
    return (c == '0) ? CW'(n - DW'(1)) : c - CW'(1);
  endfunction

  ctrl_state_t state_r, state_nxt;

  logic              func_r, water_r, sand_r;
  logic [SW-1:0]     cnt_r;
  logic [CW-1:0]     x_q, y_q;
  logic [CW-1:0]     xp_r, xm_r, yp_r, ym_r, xp0_r, xm0_r;
  logic [KW-1:0]     ix_r, iy_r;
  logic [WW-1:0]     wx, wy;
  logic [PW-1:0]     wprod_r;
  logic              rdv_r;
  logic [FERT_W-1:0] acc_r;
  logic              rem_load, rem_step;
  logic              row_end, scan_end;

  mtkf_rem #(.MAX_DIM(MAX_DIM)) u_rem_x (
    .clk      (clk),
    .load     (rem_load),
    .step     (rem_step),
    .dividend (in_tile_x),
    .divisor  (w_eff),
    .rem      (x_q)
  );

  mtkf_rem #(.MAX_DIM(MAX_DIM)) u_rem_y (
    .clk      (clk),
    .load     (rem_load),
    .step     (rem_step),
    .dividend (in_tile_y),
    .divisor  (h_eff),
    .rem      (y_q)
  );

  assign row_end  = (32'(ix_r) == KMAX);
  assign scan_end = row_end && (32'(iy_r) == KMAX);

  // triangular weights from the offset counters
  always_comb begin
    if (32'(ix_r) <= RADIUS) begin
      wx = WW'(32'(ix_r) + 1);
    end else begin
      wx = WW'(KMAX + 1 - 32'(ix_r));
    end
    if (32'(iy_r) <= RADIUS) begin
      wy = WW'(32'(iy_r) + 1);
    end else begin
      wy = WW'(KMAX + 1 - 32'(iy_r));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (cnt_r == SW'(MOD_STEPS - 1)) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        state_nxt = (func_r == FUNC_LOAD) ? ST_IDLE : ST_PRE;
      end
      ST_PRE: begin
        if (cnt_r == SW'(RADIUS - 1)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rem_load = 1'b0;
    rem_step = 1'b0;
    wr       = '0;
    rd_en    = 1'b0;
    push     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rem_load = in_valid;
      end
      ST_MOD: begin
        rem_step = 1'b1;
      end
      ST_SEED: begin
        wr.we    = (func_r == FUNC_LOAD);
        wr.water = water_r;
        wr.sand  = sand_r;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
      end
      ST_FIN: begin
        push = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign wr_addr    = {y_q, x_q};
  assign water_addr = {yp_r, xp_r};
  assign sand_addr  = {ym_r, xm_r};
  assign push_data  = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_r  <= in_func;
          water_r <= in_water;
          sand_r  <= in_sand;
        end
        cnt_r <= '0;
      end
      ST_MOD: begin
        cnt_r <= cnt_r + SW'(1);
      end
      ST_SEED: begin
        xp_r  <= x_q;
        xm_r  <= x_q;
        yp_r  <= y_q;
        ym_r  <= y_q;
        cnt_r <= '0;
      end
      ST_PRE: begin
        // walk to the corner offsets: +d starts at -RADIUS, -d at +RADIUS
        xp_r  <= dec_wrap(xp_r, w_eff);
        xm_r  <= inc_wrap(xm_r, w_eff);
        yp_r  <= dec_wrap(yp_r, h_eff);
        ym_r  <= inc_wrap(ym_r, h_eff);
        xp0_r <= dec_wrap(xp_r, w_eff);
        xm0_r <= inc_wrap(xm_r, w_eff);
        cnt_r <= cnt_r + SW'(1);
        ix_r  <= '0;
        iy_r  <= '0;
      end
      ST_SCAN: begin
        wprod_r <= PW'(wx) * PW'(wy);
        if (row_end) begin
          ix_r <= '0;
          xp_r <= xp0_r;
          xm_r <= xm0_r;
          iy_r <= iy_r + KW'(1);
          yp_r <= inc_wrap(yp_r, h_eff);
          ym_r <= dec_wrap(ym_r, h_eff);
        end else begin
          ix_r <= ix_r + KW'(1);
          xp_r <= inc_wrap(xp_r, w_eff);
          xm_r <= dec_wrap(xm_r, w_eff);
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  // memory data lines up with the weight product in the cycle after the read
  always_ff @(posedge clk) begin
    if (state_r == ST_PRE) begin
      acc_r <= '0;
    end else if (rdv_r && water_bit && !sand_bit) begin
      acc_r <= acc_r + FERT_W'(wprod_r);
    end
  end

endmodule

>>> src/masked_triangle_kernel_fertility_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when            Carries
// in_ch     sink       valid & ready           func, tile_x, tile_y, water_flag, sand_flag
// out_ch    source     valid & ready           fertility
// cfg_*     APB slave  psel&penable&pwrite     map_width at 0x0, map_height at 0x4
//
// A load runs the bit-serial reduction of the tile coordinates, then one memory
// write, then returns to idle, where the input is ready again.
// A query runs the same reduction, walks to the kernel corner and scans the kernel
// window, reading one water bit and one sand bit per cycle from the single-port maps.
// Reset (synchronous, rst_n low) clears control state and sets both map
// dimensions to 256; the maps themselves hold no reset value.
// A result waits in the output register while the next item is taken; a query
// stalls in its last state only while that register is still full.

module masked_triangle_kernel_fertility_unit import mtkf_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int RADIUS  = RADIUS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  mtkf_in_if.sink            in_ch,
  mtkf_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [APB_AW-1:0]  cfg_paddr,
  input  logic [APB_DW-1:0]  cfg_pwdata,
  output logic [APB_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  logic [DIM_REG_W-1:0] width_r, height_r;
  logic [DW-1:0]        w_eff, h_eff;
  logic                 cfg_wr;

  store_wr_t            wr;
  logic [2*CW-1:0]      wr_addr, water_addr, sand_addr;
  logic                 rd_en, water_bit, sand_bit;

  logic                 push, out_free;
  logic [FERT_W-1:0]    push_data;
  logic                 res_valid_r;
  logic [FERT_W-1:0]    res_r;

  // Configuration registers: write on the access phase, read back zero-extended.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MAP_WIDTH) begin
        width_r <= cfg_pwdata[DIM_REG_W-1:0];
      end else begin
        height_r <= cfg_pwdata[DIM_REG_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_MAP_WIDTH) begin
      cfg_prdata = APB_DW'(width_r);
    end else begin
      cfg_prdata = APB_DW'(height_r);
    end
  end

  // Clamp the dimensions: zero acts as 1, anything above MAX_DIM as MAX_DIM.
  always_comb begin
    if (width_r == '0) begin
      w_eff = DW'(1);
    end else if (32'(width_r) > MAX_DIM) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = DW'(1);
    end else if (32'(height_r) > MAX_DIM) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(height_r);
    end
  end

  // Sequencer: coordinate reduction, map write or kernel scan, accumulation.
  mtkf_ctrl #(.MAX_DIM(MAX_DIM), .RADIUS(RADIUS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_func    (in_ch.func),
    .in_tile_x  (in_ch.tile_x),
    .in_tile_y  (in_ch.tile_y),
    .in_water   (in_ch.water_flag),
    .in_sand    (in_ch.sand_flag),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .water_addr (water_addr),
    .sand_addr  (sand_addr),
    .water_bit  (water_bit),
    .sand_bit   (sand_bit),
    .out_free   (out_free),
    .push       (push),
    .push_data  (push_data)
  );

  // Water and sand maps, one bit per tile, row-major with a power-of-two pitch.
  mtkf_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk        (clk),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .water_addr (water_addr),
    .sand_addr  (sand_addr),
    .water_bit  (water_bit),
    .sand_bit   (sand_bit)
  );

  // Output register: hold the result until the sink takes the transfer.
  assign out_free = !res_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (push) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= push_data;
    end
  end

  assign out_ch.valid     = res_valid_r;
  assign out_ch.fertility = res_r;

`ifndef NO_ASSERTIONS
  // neither map's port sees a write and a read together
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n) !(wr.we && rd_en))
    else $error("map write collides with scan read");

  // never overwrite a result the sink has not taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!res_valid_r || out_ch.ready))
    else $error("result pushed into a full output register");

  // an accepted item keeps the input closed for the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input reopened right after a transfer");

  // a result never leaves the sequencer right after a transfer
  a_no_early_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !push)
    else $error("result pushed right after a transfer");
`endif

endmodule
